/* rtl/rpi_pkg.sv */
// shared widths, register codes and side-band types for the ray/plane intersection unit
package rpi_pkg;

	localparam int FRAC_BITS = 16;

	// divider: 96-bit dividend, 64-bit divisor, 41 quotient bits
	localparam int DVD_W   = 96;
	localparam int DVS_W   = 64;
	localparam int QUO_W   = 41;
	localparam int DIV_LAT = QUO_W + 1;

	// square root: 82-bit radicand, 41-bit root
	localparam int SQX_W    = 82;
	localparam int ROOT_W   = 41;
	localparam int SQRT_LAT = ROOT_W + 1;

	typedef enum logic [2:0] {
		REG_PNT_X = 3'd0,
		REG_PNT_Y = 3'd1,
		REG_PNT_Z = 3'd2,
		REG_NRM_X = 3'd3,
		REG_NRM_Y = 3'd4,
		REG_NRM_Z = 3'd5,
		REG_COLOR = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic            hit;
		logic            flip;
		logic [2:0]      dneg;
		logic [2:0][31:0] org;
	} div_side_t;

	typedef struct packed {
		logic            hit;
		logic            flip;
		logic [2:0][31:0] hpt;
	} sqrt_side_t;

endpackage

/* rtl/ray_plane_intersect_unit.sv */
// ray/plane intersection unit: one ray word in, one hit word out per cycle, unless stalled
//
// Takes one ray word every cycle while the output is not stalled and returns one result
// word per ray, in order: front stages of dot products, partial products and magnitudes,
// then a 41-stage divider (one quotient bit per stage) giving the offset along the ray
// and the squared normal components, registers forming the squared distance, a 41-stage
// square root (one root bit per stage) for the distance and the unit normal, and the
// output register. A stall on the output side freezes the whole pipeline; nothing is lost
// or repeated. Plane registers are written through the cfg channel, which is always ready;
// write them only while no ray is in flight.
module ray_plane_intersect_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] ray_origin_x,
	input  logic signed [31:0] ray_origin_y,
	input  logic signed [31:0] ray_origin_z,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic signed [17:0] surf_normal_x,
	output logic signed [17:0] surf_normal_y,
	output logic signed [17:0] surf_normal_z,
	output logic signed [31:0] hit_distance,
	output logic [23:0]        hit_color
);
	import rpi_pkg::*;

	localparam logic [31:0] DIST_MISS = 32'(-(longint'(1) << FRAC_BITS));
	localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] INT_MIN   = 32'h8000_0000;

	logic en;

	// plane registers
	logic signed [31:0] pnt_q [3];
	logic signed [31:0] nrm_q [3];
	logic [23:0]        color_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnt_q[0] <= '0;
			pnt_q[1] <= '0;
			pnt_q[2] <= '0;
			nrm_q[0] <= '0;
			nrm_q[1] <= 32'(longint'(1) << FRAC_BITS);
			nrm_q[2] <= '0;
			color_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PNT_X: pnt_q[0] <= cfg_data;
				REG_PNT_Y: pnt_q[1] <= cfg_data;
				REG_PNT_Z: pnt_q[2] <= cfg_data;
				REG_NRM_X: nrm_q[0] <= cfg_data;
				REG_NRM_Y: nrm_q[1] <= cfg_data;
				REG_NRM_Z: nrm_q[2] <= cfg_data;
				REG_COLOR: color_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic signed [31:0] org_c [3];
	logic signed [31:0] dir_c [3];
	logic signed [32:0] diff_c [3];
	logic signed [63:0] nsqr_c [3];

	always_comb begin
		org_c[0] = ray_origin_x;
		org_c[1] = ray_origin_y;
		org_c[2] = ray_origin_z;
		dir_c[0] = ray_dir_x;
		dir_c[1] = ray_dir_y;
		dir_c[2] = ray_dir_z;
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = {pnt_q[i][31], pnt_q[i]} - {org_c[i][31], org_c[i]};
			nsqr_c[i] = nrm_q[i] * nrm_q[i];
		end
	end

	// front stages: dot products, magnitudes, dividends
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [64:0] pn_s1 [3];
	logic signed [63:0] pd_s1 [3];
	logic [62:0]        nn_s1 [3];
	logic [31:0]        org_s1 [3];
	logic [31:0]        dir_s1 [3];

	logic signed [66:0] num_s2;
	logic signed [65:0] den_s2;
	logic [63:0]        nsq_s2;
	logic [62:0]        nn_s2 [3];
	logic [31:0]        org_s2 [3];
	logic [31:0]        dir_s2 [3];

	logic [64:0]        nmag_s3;
	logic [63:0]        dmag_s3;
	logic [31:0]        rmag_s3 [3];
	logic [63:0]        nsq_s3;
	logic [62:0]        nn_s3 [3];
	div_side_t          sd_s3;

	logic [63:0]        plo_s4 [3];
	logic [64:0]        phi_s4 [3];
	logic [63:0]        dmag_s4;
	logic [63:0]        nsq_s4;
	logic [62:0]        nn_s4 [3];
	div_side_t          sd_s4;

	logic [DVD_W-1:0]   rdvd_s5 [3];
	logic [DVD_W-1:0]   ndvd_s5 [3];
	logic [63:0]        dmag_s5;
	logic [63:0]        nsq_s5;
	div_side_t          sd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pn_s1[i]  <= nrm_q[i] * diff_c[i];
				pd_s1[i]  <= nrm_q[i] * dir_c[i];
				nn_s1[i]  <= nsqr_c[i][62:0];
				org_s1[i] <= org_c[i];
				dir_s1[i] <= dir_c[i];
			end

			num_s2 <= 67'(pn_s1[0]) + 67'(pn_s1[1]) + 67'(pn_s1[2]);
			den_s2 <= 66'(pd_s1[0]) + 66'(pd_s1[1]) + 66'(pd_s1[2]);
			nsq_s2 <= 64'(nn_s1[0]) + 64'(nn_s1[1]) + 64'(nn_s1[2]);
			for (int i = 0; i < 3; i++) begin
				nn_s2[i]  <= nn_s1[i];
				org_s2[i] <= org_s1[i];
				dir_s2[i] <= dir_s1[i];
			end

			// a hit needs num and den nonzero with the same sign
			sd_s3.hit  <= (num_s2 != '0) && (den_s2 != '0) && (num_s2[66] == den_s2[65]);
			sd_s3.flip <= !den_s2[65];
			nmag_s3    <= num_s2[66] ? 65'(-num_s2) : 65'(num_s2);
			dmag_s3    <= den_s2[65] ? 64'(-den_s2) : 64'(den_s2);
			nsq_s3     <= nsq_s2;
			for (int i = 0; i < 3; i++) begin
				sd_s3.dneg[i] <= dir_s2[i][31];
				sd_s3.org[i]  <= org_s2[i];
				rmag_s3[i]    <= dir_s2[i][31] ? 32'(-dir_s2[i]) : dir_s2[i];
				nn_s3[i]      <= nn_s2[i];
			end

			for (int i = 0; i < 3; i++) begin
				plo_s4[i] <= rmag_s3[i] * nmag_s3[31:0];
				phi_s4[i] <= 65'(rmag_s3[i]) * 65'(nmag_s3[64:32]);
				nn_s4[i]  <= nn_s3[i];
			end
			dmag_s4 <= dmag_s3;
			nsq_s4  <= nsq_s3;
			sd_s4   <= sd_s3;

			for (int i = 0; i < 3; i++) begin
				rdvd_s5[i] <= DVD_W'(plo_s4[i]) + (DVD_W'(phi_s4[i]) << 32);
				ndvd_s5[i] <= DVD_W'(nn_s4[i]) << (2 * FRAC_BITS);
			end
			dmag_s5 <= dmag_s4;
			nsq_s5  <= nsq_s4;
			sd_s5   <= sd_s4;
		end
	end

	// dividers: offset along the ray and squared unit-normal components
	logic [QUO_W-1:0] rq_c [3];
	logic [QUO_W-1:0] nq_c [3];

	for (genvar g = 0; g < 3; g++) begin : g_div
		rpi_div u_div_ray (
			.clk      (clk),
			.en       (en),
			.dividend (rdvd_s5[g]),
			.divisor  (dmag_s5),
			.quotient (rq_c[g])
		);
		rpi_div u_div_nrm (
			.clk      (clk),
			.en       (en),
			.dividend (ndvd_s5[g]),
			.divisor  (nsq_s5),
			.quotient (nq_c[g])
		);
	end

	logic      dvld_d [0:DIV_LAT-1];
	div_side_t dsd_d  [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				dvld_d[k] <= 1'b0;
			end
		end else if (en) begin
			dvld_d[0] <= vld_s5;
			for (int k = 1; k < DIV_LAT; k++) begin
				dvld_d[k] <= dvld_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsd_d[0] <= sd_s5;
			for (int k = 1; k < DIV_LAT; k++) begin
				dsd_d[k] <= dsd_d[k-1];
			end
		end
	end

	// hit point and partial squares of the offset
	div_side_t        dsd_c;
	logic [41:0]      qs_c  [3];
	logic [42:0]      sum_c [3];
	logic [31:0]      hp_c  [3];

	always_comb begin
		dsd_c = dsd_d[DIV_LAT-1];
		for (int i = 0; i < 3; i++) begin
			qs_c[i]  = dsd_c.dneg[i] ? 42'(-{1'b0, rq_c[i]}) : {1'b0, rq_c[i]};
			sum_c[i] = {{11{dsd_c.org[i][31]}}, dsd_c.org[i]} + {qs_c[i][41], qs_c[i]};
			if ((&sum_c[i][42:31]) || !(|sum_c[i][42:31])) begin
				hp_c[i] = sum_c[i][31:0];
			end else begin
				hp_c[i] = sum_c[i][42] ? INT_MIN : INT_MAX;
			end
		end
	end

	logic             vld_s6, vld_s7;
	logic [39:0]      aa_s6 [3];
	logic [40:0]      ab_s6 [3];
	logic [41:0]      bb_s6 [3];
	logic [32:0]      nq_s6 [3];
	sqrt_side_t       sd_s6;

	logic [SQX_W-1:0] dsq_s7;
	logic [32:0]      nq_s7 [3];
	sqrt_side_t       sd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dvld_d[DIV_LAT-1];
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// offset split as a*2^21 + b to keep the multipliers narrow
			for (int i = 0; i < 3; i++) begin
				aa_s6[i]     <= rq_c[i][40:21] * rq_c[i][40:21];
				ab_s6[i]     <= 41'(rq_c[i][40:21]) * 41'(rq_c[i][20:0]);
				bb_s6[i]     <= rq_c[i][20:0] * rq_c[i][20:0];
				nq_s6[i]     <= nq_c[i][32:0];
				sd_s6.hpt[i] <= hp_c[i];
			end
			sd_s6.hit  <= dsd_c.hit;
			sd_s6.flip <= dsd_c.flip;

			dsq_s7 <= (SQX_W'(aa_s6[0]) << 42) + (SQX_W'(ab_s6[0]) << 22) + SQX_W'(bb_s6[0])
				+ (SQX_W'(aa_s6[1]) << 42) + (SQX_W'(ab_s6[1]) << 22) + SQX_W'(bb_s6[1])
				+ (SQX_W'(aa_s6[2]) << 42) + (SQX_W'(ab_s6[2]) << 22) + SQX_W'(bb_s6[2]);
			for (int i = 0; i < 3; i++) begin
				nq_s7[i] <= nq_s6[i];
			end
			sd_s7 <= sd_s6;
		end
	end

	// square roots: distance and unit-normal magnitudes
	logic [ROOT_W-1:0] dr_c;
	logic [ROOT_W-1:0] nr_c [3];

	rpi_sqrt u_sqrt_dist (
		.clk      (clk),
		.en       (en),
		.radicand (dsq_s7),
		.root     (dr_c)
	);

	for (genvar g = 0; g < 3; g++) begin : g_sqrt
		rpi_sqrt u_sqrt_nrm (
			.clk      (clk),
			.en       (en),
			.radicand (SQX_W'(nq_s7[g])),
			.root     (nr_c[g])
		);
	end

	logic       svld_d [0:SQRT_LAT-1];
	sqrt_side_t ssd_d  [0:SQRT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQRT_LAT; k++) begin
				svld_d[k] <= 1'b0;
			end
		end else if (en) begin
			svld_d[0] <= vld_s7;
			for (int k = 1; k < SQRT_LAT; k++) begin
				svld_d[k] <= svld_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssd_d[0] <= sd_s7;
			for (int k = 1; k < SQRT_LAT; k++) begin
				ssd_d[k] <= ssd_d[k-1];
			end
		end
	end

	// output word
	sqrt_side_t  ssd_c;
	logic [17:0] un_c [3];
	logic [17:0] sn_c [3];
	logic [31:0] dist_c;

	always_comb begin
		ssd_c = ssd_d[SQRT_LAT-1];
		for (int i = 0; i < 3; i++) begin
			un_c[i] = 18'(nr_c[i][16:0]);
			// normal turned against the ray
			sn_c[i] = (nrm_q[i][31] ^ ssd_c.flip) ? 18'(-un_c[i]) : un_c[i];
		end
		dist_c = (|dr_c[ROOT_W-1:31]) ? INT_MAX : {1'b0, dr_c[30:0]};
	end

	logic        out_valid_q;
	logic        hit_q;
	logic [31:0] hx_q, hy_q, hz_q, dist_q;
	logic [17:0] nx_q, ny_q, nz_q;
	logic [23:0] color_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= svld_d[SQRT_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= ssd_c.hit;
			if (ssd_c.hit) begin
				hx_q        <= ssd_c.hpt[0];
				hy_q        <= ssd_c.hpt[1];
				hz_q        <= ssd_c.hpt[2];
				nx_q        <= sn_c[0];
				ny_q        <= sn_c[1];
				nz_q        <= sn_c[2];
				dist_q      <= dist_c;
				color_out_q <= color_q;
			end else begin
				hx_q        <= '0;
				hy_q        <= '0;
				hz_q        <= '0;
				nx_q        <= '0;
				ny_q        <= '0;
				nz_q        <= '0;
				dist_q      <= DIST_MISS;
				color_out_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign hit_x         = hx_q;
	assign hit_y         = hy_q;
	assign hit_z         = hz_q;
	assign surf_normal_x = nx_q;
	assign surf_normal_y = ny_q;
	assign surf_normal_z = nz_q;
	assign hit_distance  = dist_q;
	assign hit_color     = color_out_q;

endmodule

/* rtl/rpi_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module rpi_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rpi_pkg::DVD_W-1:0]  dividend,
	input  logic [rpi_pkg::DVS_W-1:0]  divisor,
	output logic [rpi_pkg::QUO_W-1:0]  quotient
);
	import rpi_pkg::*;

	localparam int STEPS = QUO_W;
	localparam logic [QUO_W-1:0] Q_LIMIT = QUO_W'(1) << (QUO_W - 1);

	logic [DVS_W-1:0] rem_s [0:STEPS];
	logic [QUO_W-1:0] low_s [0:STEPS];
	logic [QUO_W-1:0] quo_s [0:STEPS];
	logic [DVS_W-1:0] dvs_s [0:STEPS];
	logic             ovf_s [0:STEPS];

	logic [DVS_W:0] trial_c [1:STEPS];
	logic [DVS_W:0] diff_c  [1:STEPS];
	logic           ge_c    [1:STEPS];

	always_comb begin
		for (int k = 1; k <= STEPS; k++) begin
			trial_c[k] = {rem_s[k-1], low_s[k-1][QUO_W-1]};
			diff_c[k]  = trial_c[k] - {1'b0, dvs_s[k-1]};
			ge_c[k]    = trial_c[k] >= {1'b0, dvs_s[k-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// top dividend bits must stay below the divisor, else the quotient overflows
			rem_s[0] <= DVS_W'(dividend[DVD_W-1:QUO_W]);
			low_s[0] <= dividend[QUO_W-1:0];
			quo_s[0] <= '0;
			dvs_s[0] <= divisor;
			ovf_s[0] <= DVS_W'(dividend[DVD_W-1:QUO_W]) >= divisor;
			for (int k = 1; k <= STEPS; k++) begin
				rem_s[k] <= ge_c[k] ? diff_c[k][DVS_W-1:0] : trial_c[k][DVS_W-1:0];
				low_s[k] <= {low_s[k-1][QUO_W-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge_c[k]};
				dvs_s[k] <= dvs_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	always_comb begin
		if (ovf_s[STEPS] || (quo_s[STEPS][QUO_W-1] && |quo_s[STEPS][QUO_W-2:0])) begin
			quotient = Q_LIMIT;
		end else begin
			quotient = quo_s[STEPS];
		end
	end

endmodule

/* rtl/rpi_sqrt.sv */
// pipelined integer square root, one root bit per stage
module rpi_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rpi_pkg::SQX_W-1:0]   radicand,
	output logic [rpi_pkg::ROOT_W-1:0]  root
);
	import rpi_pkg::*;

	localparam int STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 4;

	logic [SQX_W-1:0]  x_s    [0:STEPS];
	logic [REM_W-1:0]  rem_s  [0:STEPS];
	logic [ROOT_W-1:0] root_s [0:STEPS];

	logic [REM_W-1:0] t_c  [1:STEPS];
	logic [REM_W-1:0] tr_c [1:STEPS];
	logic             ge_c [1:STEPS];

	always_comb begin
		for (int k = 1; k <= STEPS; k++) begin
			t_c[k]  = {rem_s[k-1][REM_W-3:0], x_s[k-1][SQX_W-1 -: 2]};
			tr_c[k] = REM_W'({root_s[k-1], 2'b01});
			ge_c[k] = t_c[k] >= tr_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= radicand;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			for (int k = 1; k <= STEPS; k++) begin
				x_s[k]    <= x_s[k-1] << 2;
				rem_s[k]  <= ge_c[k] ? (t_c[k] - tr_c[k]) : t_c[k];
				root_s[k] <= {root_s[k-1][ROOT_W-2:0], ge_c[k]};
			end
		end
	end

	assign root = root_s[STEPS];

endmodule

/* bench/tb.sv */
// self-checking bench for the ray/plane intersection unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpi_pkg::*;

	localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;
	localparam int PIPE_LAT = 92;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] ONE = 32'sd65536;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [31:0] ox, oy, oz, dx, dy, dz;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] x, y, z;
		logic signed [17:0] nx, ny, nz;
		logic signed [31:0] distance;
		logic [23:0]        rgb;
	} hit_word_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic [31:0] data;
	} cfg_word_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] ray_origin_x, ray_origin_y, ray_origin_z;
	logic signed [31:0] ray_dir_x, ray_dir_y, ray_dir_z;
	logic out_valid, out_ready;
	logic hit;
	logic signed [31:0] hit_x, hit_y, hit_z, hit_distance;
	logic signed [17:0] surf_normal_x, surf_normal_y, surf_normal_z;
	logic [23:0] hit_color;

	ray_plane_intersect_unit dut (.*);

	ray_t      pending_rays[$];
	cfg_word_t pending_cfg[$];
	hit_word_t expected_hits[$];

	// plane as the bench believes it is
	logic signed [31:0] plane_reg[6];
	logic [23:0]        plane_rgb;

	int errors = 0;
	int cycles = 0;
	int burst_left = 0, gap_left = 0;
	int stall_mode = 0, mode_left = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic logic [127:0] isqrt(input logic [127:0] v);
		logic [127:0] r, c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	function automatic hit_word_t trace_ray(input ray_t r);
		logic signed [71:0] oe[3], de[3], pe[3], ne[3];
		logic signed [71:0] num, den;
		logic [127:0] nm, dm, qm, dsq, nsq, dmag, nmag, u;
		logic signed [63:0] qv, hv;
		logic flip, neg;
		hit_word_t w;
		oe[0] = r.ox; oe[1] = r.oy; oe[2] = r.oz;
		de[0] = r.dx; de[1] = r.dy; de[2] = r.dz;
		num = 0; den = 0;
		for (int i = 0; i < 3; i++) begin
			pe[i] = plane_reg[i];
			ne[i] = plane_reg[3 + i];
			num += ne[i] * (pe[i] - oe[i]);
			den += ne[i] * de[i];
		end
		w = '0;
		if (num == 0 || den == 0 || ((num < 0) != (den < 0))) begin
			w.distance = -ONE;
			return w;
		end
		nm = (num < 0) ? -num : num;
		dm = (den < 0) ? -den : den;
		dsq = 0; nsq = 0;
		for (int i = 0; i < 3; i++) begin
			dmag = (de[i] < 0) ? -de[i] : de[i];
			qm = nm * dmag / dm;
			if (qm > (128'd1 << 40)) qm = 128'd1 << 40;
			qv = (de[i] < 0) ? -$signed(qm[63:0]) : $signed(qm[63:0]);
			hv = oe[i] + qv;
			if (hv > S32_MAX) hv = S32_MAX;
			if (hv < S32_MIN) hv = S32_MIN;
			case (i)
				0: w.x = hv[31:0];
				1: w.y = hv[31:0];
				default: w.z = hv[31:0];
			endcase
			dsq += qm * qm;
			nmag = (ne[i] < 0) ? -ne[i] : ne[i];
			nsq += nmag * nmag;
		end
		flip = den > 0;
		for (int i = 0; i < 3; i++) begin
			nmag = (ne[i] < 0) ? -ne[i] : ne[i];
			u = isqrt(((nmag * nmag) << (2 * FRAC_BITS)) / nsq);
			neg = (ne[i] < 0) != flip;
			if (u > 128'd131071) u = neg ? 128'd131072 : 128'd131071;
			hv = neg ? -$signed(u[63:0]) : $signed(u[63:0]);
			case (i)
				0: w.nx = hv[17:0];
				1: w.ny = hv[17:0];
				default: w.nz = hv[17:0];
			endcase
		end
		u = isqrt(dsq);
		w.distance = (u > 128'h7fff_ffff) ? S32_MAX : $signed(u[31:0]);
		w.hit = 1'b1;
		w.rgb = plane_rgb;
		return w;
	endfunction

	// driver: ray and cfg channels, expectations formed at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{ray_origin_x, ray_origin_y, ray_origin_z} <= '0;
			{ray_dir_x, ray_dir_y, ray_dir_z} <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			for (int i = 0; i < 6; i++) plane_reg[i] <= (i == REG_NRM_Y) ? ONE : '0;
			plane_rgb <= '0;
		end else begin
			automatic logic busy_in = in_valid;
			automatic logic busy_cfg = cfg_valid;
			automatic ray_t nr;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_COLOR) plane_rgb <= cfg_data[23:0];
				else if (cfg_index != CFG_IDX_UNUSED) plane_reg[cfg_index] <= cfg_data;
				busy_cfg = 1'b0;
			end
			if (!busy_cfg && pending_cfg.size() > 0) begin
				cfg_index <= pending_cfg[0].idx;
				cfg_data <= pending_cfg[0].data;
				void'(pending_cfg.pop_front());
				busy_cfg = 1'b1;
			end
			cfg_valid <= busy_cfg;

			if (in_valid && in_ready) begin
				expected_hits.push_back(trace_ray({ray_origin_x, ray_origin_y, ray_origin_z,
					ray_dir_x, ray_dir_y, ray_dir_z}));
				busy_in = 1'b0;
			end
			if (!busy_in) begin
				if (gap_left > 0) gap_left--;
				else if (pending_rays.size() > 0) begin
					nr = pending_rays.pop_front();
					{ray_origin_x, ray_origin_y, ray_origin_z} <= {nr.ox, nr.oy, nr.oz};
					{ray_dir_x, ray_dir_y, ray_dir_z} <= {nr.dx, nr.dy, nr.dz};
					busy_in = 1'b1;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
					end
				end
			end
			in_valid <= busy_in;
		end
	end

	task automatic check_field(input string fname, input logic [31:0] e, a);
		if (e !== a) begin
			$display("%0t mismatch %s expected %h actual %h", $time, fname, e, a);
			errors++;
		end
	endtask

	// monitor: result side with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			automatic hit_word_t e;
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				if (out_valid && out_ready) begin
					if (expected_hits.size() == 0) begin
						$display("%0t unexpected result word, hit %b", $time, hit);
						errors++;
					end else begin
						e = expected_hits.pop_front();
						check_field("hit", e.hit, hit);
						check_field("hit_x", e.x, hit_x);
						check_field("hit_y", e.y, hit_y);
						check_field("hit_z", e.z, hit_z);
						check_field("surf_normal_x", 32'(e.nx), 32'(surf_normal_x));
						check_field("surf_normal_y", 32'(e.ny), 32'(surf_normal_y));
						check_field("surf_normal_z", 32'(e.nz), 32'(surf_normal_z));
						check_field("hit_distance", e.distance, hit_distance);
						check_field("hit_color", e.rgb, hit_color);
					end
				end
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end else mode_left--;
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) != 0);
					default: out_ready <= (cycles % 7) < 2;
				endcase
			end
		end
	end

	function automatic logic signed [31:0] rand_coord(input logic signed [31:0] base);
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: case ($urandom_range(0, 3))
				0: return S32_MIN;
				1: return S32_MAX;
				2: return 0;
				default: return -1;
			endcase
			default: return base + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	task automatic add_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz);
		ray_t r;
		r = '{ox, oy, oz, dx, dy, dz};
		pending_rays.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_rays.size() > 0 || pending_cfg.size() > 0 || in_valid || cfg_valid
			|| expected_hits.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	task automatic set_plane(input logic [31:0] v[7]);
		cfg_word_t c;
		for (int i = 0; i < 7; i++) begin
			c.idx = i[2:0];
			c.data = v[i];
			pending_cfg.push_back(c);
		end
	endtask

	initial begin
		logic [31:0] pv[7];
		cfg_word_t c;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset plane is y = 0 facing +y
		add_ray(0, ONE, 0, 0, -ONE, 0);
		add_ray(0, -ONE, 0, 0, ONE, 0);
		add_ray(0, ONE, 0, ONE, 0, 0);
		add_ray(ONE, 0, ONE, 0, -ONE, ONE);
		add_ray(0, ONE, 0, 0, ONE, 0);
		add_ray(0, ONE, 0, 0, 0, 0);
		add_ray(S32_MAX, ONE, 0, S32_MAX, -ONE, 0);
		add_ray(S32_MIN, ONE, S32_MIN, S32_MIN, -ONE, S32_MAX);
		add_ray(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
		add_ray(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN);
		add_ray(0, S32_MAX, 0, S32_MAX, -1, S32_MIN);
		add_ray(0, S32_MIN, 0, S32_MIN, 1, S32_MAX);
		add_ray(3 * ONE, 5 * ONE, -2 * ONE, ONE, -ONE, ONE / 2);
		add_ray(-1, 1, -1, -1, -1, -1);
		add_ray(0, 1, 0, 0, -1, 0);
		wait_idle();

		// out-of-range index must leave the plane alone
		c.idx = CFG_IDX_UNUSED;
		c.data = 32'hdead_beef;
		pending_cfg.push_back(c);
		wait_idle();
		add_ray(0, ONE, 0, ONE, -ONE, 0);

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			case (ph)
				0: pv = '{S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 32'hffff_ffff};
				1: pv = '{S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 32'h0};
				2: pv = '{ONE, 0, -ONE, 0, 0, 0, 32'h00ab_cdef}; // degenerate normal
				3: pv = '{0, 0, 0, 1, -1, 1, $urandom};
				default: begin
					for (int i = 0; i < 3; i++) pv[i] = rand_coord(0);
					for (int i = 3; i < 6; i++)
						pv[i] = ($urandom_range(0, 3) == 0) ? $urandom
							: $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
					pv[6] = $urandom;
				end
			endcase
			set_plane(pv);
			wait_idle();
			for (int k = 0; k < 170; k++) begin
				if ($urandom_range(0, 4) == 0)
					add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				else
					add_ray(rand_coord(pv[0]), rand_coord(pv[1]), rand_coord(pv[2]),
						rand_coord(0), rand_coord(0), rand_coord(0));
			end
		end

		wait_idle();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

/* ray_plane_intersect_unit.f */
rtl/rpi_pkg.sv
rtl/rpi_div.sv
rtl/rpi_sqrt.sv
rtl/ray_plane_intersect_unit.sv
bench/tb.sv
